[rtl/core/dlm_pkg.sv]
// Shared types, register codes and arithmetic helpers of the deck level meter.
package dlm_pkg;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_SMOOTHING_GAIN  = 3'd0;
    localparam logic [2:0] REG_PEAK_DECAY_GAIN = 3'd1;
    localparam logic [2:0] REG_PEAK_HOLD       = 3'd2;
    localparam logic [2:0] REG_AUDIBLE_THR     = 3'd3;
    localparam logic [2:0] REG_WARMUP_THR      = 3'd4;
    localparam logic [2:0] REG_WARMUP_NEEDED   = 3'd5;

    localparam logic [15:0] RST_SMOOTHING_GAIN  = 16'd13107;
    localparam logic [15:0] RST_PEAK_DECAY_GAIN = 16'd62915;
    localparam logic [3:0]  RST_PEAK_HOLD       = 4'd8;
    localparam logic [15:0] RST_AUDIBLE_THR     = 16'd1036;
    localparam logic [15:0] RST_WARMUP_THR      = 16'd164;
    localparam logic [7:0]  RST_WARMUP_NEEDED   = 8'd50;

    typedef struct packed {
        logic [15:0] smoothing_gain;
        logic [15:0] peak_decay_gain;
        logic [3:0]  peak_hold_blocks;
        logic [15:0] audible_threshold;
        logic [15:0] warmup_threshold;
        logic [7:0]  warmup_blocks_needed;
    } t_cfg;

    // One deck's stored meter state.
    typedef struct packed {
        logic [15:0] rms_avg;
        logic [15:0] peak;
        logic [3:0]  hold;
    } t_deck_entry;

    typedef struct packed {
        logic [15:0] level;
        logic [3:0]  hold;
    } t_peak;

    typedef struct packed {
        logic [15:0] rms;
        logic [15:0] peak;
        logic        warm;
    } t_master_res;

    // avg + floor(gain * (x - avg) / 65536), kept inside 0..65535.
    function automatic logic [15:0] smooth_step(input logic [15:0] gain,
                                                input logic [15:0] avg,
                                                input logic [15:0] x);
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        logic signed [17:0] step;
        logic signed [18:0] sum;
        diff = $signed({1'b0, x}) - $signed({1'b0, avg});
        prod = $signed({1'b0, gain}) * diff;
        step = $signed(prod[33:16]);
        sum  = $signed({3'b000, avg}) + 19'(step);
        if (sum < 0) begin
            return 16'd0;
        end else if (sum > 19'sd65535) begin
            return 16'hFFFF;
        end
        return sum[15:0];
    endfunction

    // Take a new peak and reload the hold, count the hold down, or decay.
    function automatic t_peak peak_step(input logic [15:0] level,
                                        input logic [3:0]  hold,
                                        input logic [15:0] peak,
                                        input logic [3:0]  hold_cfg,
                                        input logic [15:0] decay_gain);
        t_peak       res;
        logic [31:0] prod;
        res  = '{level: level, hold: hold};
        prod = level * decay_gain;
        if (peak >= level) begin
            res.level = peak;
            res.hold  = hold_cfg;
        end else if (hold != 4'd0) begin
            res.hold = hold - 4'd1;
        end else begin
            res.level = prod[31:16];
        end
        return res;
    endfunction

endpackage

[rtl/core/deck_level_meter.sv]
// Top level of the deck level meter: register port, deck pipeline and result register.
//
// Usage. Each audio block the host sends one input beat per deck, decks in
// order, with last_deck set on the final one. Every accepted beat yields exactly
// one result beat carrying that deck's smoothed RMS, held or decaying peak and
// the public-facing flag. The result for the last deck also carries the master
// smoothed RMS, the master held peak and sets block_done; on other beats the
// master fields read zero. warmup_complete is the sticky warm-up flag as it
// stands after the beat. Deck numbers at or above DECKS leave deck state alone
// and report zero deck fields.
// A beat passes stage 1, stage 2 and the stage 3 result register before its
// result shows on the output. Throughput is one beat per cycle while the receiver
// takes results, set by the read-modify-write loop around the registered-read deck
// state memory; a write is forwarded to a read of the same deck in the same cycle,
// so repeated decks need no stall. The pipeline holds three beats; when the
// receiver stalls, empty stages still fill, so input beats keep being accepted until
// every stage is occupied. Reset (synchronous, active low) clears all meter state
// at once through valid bits on the deck memory, with no clearing pass, and loads
// the register defaults. The host must write registers over the APB-style port only while idle (not enforced).
module deck_level_meter
    import dlm_pkg::*;
#(
    parameter int DECKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_deck_index,
    input  logic [15:0] i_deck_rms,
    input  logic [15:0] i_deck_peak,
    input  logic        i_deck_sounding,
    input  logic        i_routed_to_master,
    input  logic [15:0] i_master_rms,
    input  logic        i_audio_running,
    input  logic        i_last_deck,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_deck_number,
    output logic [15:0] o_deck_rms_smoothed,
    output logic [15:0] o_deck_peak_held,
    output logic        o_public_facing,
    output logic [15:0] o_master_rms_smoothed,
    output logic [15:0] o_master_peak_held,
    output logic        o_warmup_complete,
    output logic        o_block_done
);

    localparam int         AW      = (DECKS > 1) ? $clog2(DECKS) : 1;
    localparam logic [4:0] DECKS_W = 5'(DECKS);

    // Configuration registers.
    t_cfg       r_cfg;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_gain       <= RST_SMOOTHING_GAIN;
            r_cfg.peak_decay_gain      <= RST_PEAK_DECAY_GAIN;
            r_cfg.peak_hold_blocks     <= RST_PEAK_HOLD;
            r_cfg.audible_threshold    <= RST_AUDIBLE_THR;
            r_cfg.warmup_threshold     <= RST_WARMUP_THR;
            r_cfg.warmup_blocks_needed <= RST_WARMUP_NEEDED;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_SMOOTHING_GAIN:  r_cfg.smoothing_gain       <= pwdata[15:0];
                REG_PEAK_DECAY_GAIN: r_cfg.peak_decay_gain      <= pwdata[15:0];
                REG_PEAK_HOLD:       r_cfg.peak_hold_blocks     <= pwdata[3:0];
                REG_AUDIBLE_THR:     r_cfg.audible_threshold    <= pwdata[15:0];
                REG_WARMUP_THR:      r_cfg.warmup_threshold     <= pwdata[15:0];
                REG_WARMUP_NEEDED:   r_cfg.warmup_blocks_needed <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SMOOTHING_GAIN:  prdata = {16'd0, r_cfg.smoothing_gain};
            REG_PEAK_DECAY_GAIN: prdata = {16'd0, r_cfg.peak_decay_gain};
            REG_PEAK_HOLD:       prdata = {28'd0, r_cfg.peak_hold_blocks};
            REG_AUDIBLE_THR:     prdata = {16'd0, r_cfg.audible_threshold};
            REG_WARMUP_THR:      prdata = {16'd0, r_cfg.warmup_threshold};
            REG_WARMUP_NEEDED:   prdata = {24'd0, r_cfg.warmup_blocks_needed};
            default:             prdata = 32'd0;
        endcase
    end

    // Stage advance: a stage moves when the one after it is empty or moving.
    logic r1_valid, r2_valid;
    logic en1, en2, en3;
    logic in_beat, in_range;

    assign en3        = !o_out_valid || i_out_ready;
    assign en2        = !r2_valid || en3;
    assign en1        = !r1_valid || en2;
    assign o_in_ready = en1;
    assign in_beat    = i_in_valid && en1;
    assign in_range   = {1'b0, i_deck_index} < DECKS_W;

    // Stage 1: the beat, with deck state arriving from the memory.
    logic [3:0]  r1_idx;
    logic        r1_in_range;
    logic [15:0] r1_rms, r1_peak, r1_mrms;
    logic        r1_sounding, r1_routed, r1_running, r1_last;
    t_deck_entry rd_entry, wr_entry;
    t_peak       deck_pk;
    logic        wr_en;
    logic [15:0] r_block_max;
    logic [15:0] n_block_max;

    dlm_deck_mem #(
        .DECKS (DECKS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_beat && in_range),
        .i_rd_addr (i_deck_index[AW-1:0]),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (r1_idx[AW-1:0]),
        .i_wr_data (wr_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r1_idx      <= i_deck_index;
            r1_in_range <= in_range;
            r1_rms      <= i_deck_rms;
            r1_peak     <= i_deck_peak;
            r1_sounding <= i_deck_sounding;
            r1_routed   <= i_routed_to_master;
            r1_mrms     <= i_master_rms;
            r1_running  <= i_audio_running;
            r1_last     <= i_last_deck;
        end
    end

    always_comb begin
        deck_pk = peak_step(rd_entry.peak, rd_entry.hold, r1_peak,
                            r_cfg.peak_hold_blocks, r_cfg.peak_decay_gain);
        wr_entry.rms_avg = smooth_step(r_cfg.smoothing_gain, rd_entry.rms_avg, r1_rms);
        wr_entry.peak    = deck_pk.level;
        wr_entry.hold    = deck_pk.hold;
        n_block_max      = r_block_max;
        if (r1_in_range && (deck_pk.level > r_block_max)) begin
            n_block_max = deck_pk.level;
        end
    end

    assign wr_en = en2 && r1_valid && r1_in_range;

    // The running block maximum restarts after the last deck has used it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_max <= '0;
        end else if (en2 && r1_valid) begin
            r_block_max <= r1_last ? 16'd0 : n_block_max;
        end
    end

    // Stage 2: deck results are final; the master update happens on the last deck.
    logic [3:0]  r2_idx;
    logic [15:0] r2_rms_s, r2_peak_h, r2_mrms, r2_bmax;
    logic        r2_pub, r2_running, r2_last;
    t_master_res m_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_idx     <= r1_idx;
            r2_rms_s   <= r1_in_range ? wr_entry.rms_avg : 16'd0;
            r2_peak_h  <= r1_in_range ? wr_entry.peak : 16'd0;
            r2_pub     <= r1_in_range && r1_sounding && r1_routed &&
                          (wr_entry.rms_avg > r_cfg.audible_threshold);
            r2_mrms    <= r1_mrms;
            r2_bmax    <= n_block_max;
            r2_running <= r1_running;
            r2_last    <= r1_last;
        end
    end

    dlm_master u_master (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_last       (r2_last),
        .i_update     (en3 && r2_valid && r2_last),
        .i_master_rms (r2_mrms),
        .i_block_peak (r2_bmax),
        .i_running    (r2_running),
        .o_res        (m_res)
    );

    // Stage 3: result register facing the receiver.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid) begin
            o_deck_number         <= r2_idx;
            o_deck_rms_smoothed   <= r2_rms_s;
            o_deck_peak_held      <= r2_peak_h;
            o_public_facing       <= r2_pub;
            o_master_rms_smoothed <= m_res.rms;
            o_master_peak_held    <= m_res.peak;
            o_warmup_complete     <= m_res.warm;
            o_block_done          <= r2_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/dlm_deck_mem.sv]
// Per-deck state memory with valid bits and write-to-read forwarding.
module dlm_deck_mem
    import dlm_pkg::*;
#(
    parameter int DECKS = 4,
    parameter int AW    = (DECKS > 1) ? $clog2(DECKS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_deck_entry   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_deck_entry   i_wr_data
);

    t_deck_entry      mem [DECKS];
    logic [DECKS-1:0] r_valid;
    t_deck_entry      r_rd_data;
    logic             r_rd_ok;
    logic             fwd;

    assign fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= fwd ? i_wr_data : mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= fwd || r_valid[i_rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

[rtl/core/dlm_master.sv]
// Master level state: smoothed RMS, held peak and the warm-up detector.
module dlm_master
    import dlm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_last,
    input  logic        i_update,
    input  logic [15:0] i_master_rms,
    input  logic [15:0] i_block_peak,
    input  logic        i_running,
    output t_master_res o_res
);

    logic [15:0] r_rms_avg;
    logic [15:0] r_peak;
    logic [3:0]  r_hold;
    logic [7:0]  r_count;
    logic        r_done;
    logic [15:0] n_rms_avg;
    t_peak       n_peak;
    logic [7:0]  n_count;
    logic        n_done;

    always_comb begin
        n_rms_avg = smooth_step(i_cfg.smoothing_gain, r_rms_avg, i_master_rms);
        n_peak    = peak_step(r_peak, r_hold, i_block_peak,
                              i_cfg.peak_hold_blocks, i_cfg.peak_decay_gain);
        n_count   = r_count;
        n_done    = r_done;
        if (i_running && !r_done) begin
            if (n_rms_avg > i_cfg.warmup_threshold) begin
                if (r_count < i_cfg.warmup_blocks_needed) begin
                    n_count = r_count + 8'd1;
                end
            end else begin
                n_count = 8'd0;
            end
            if (n_count >= i_cfg.warmup_blocks_needed) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rms_avg <= '0;
            r_peak    <= '0;
            r_hold    <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else if (i_update) begin
            r_rms_avg <= n_rms_avg;
            r_peak    <= n_peak.level;
            r_hold    <= n_peak.hold;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    assign o_res.rms  = i_last ? n_rms_avg : 16'd0;
    assign o_res.peak = i_last ? n_peak.level : 16'd0;
    assign o_res.warm = i_last ? n_done : r_done;

endmodule

[rtl/core/dlm_checker.sv]
// Port-level checks of the deck level meter, bound to the top level.
module dlm_checker #(
    parameter int DECKS = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_deck_number,
    input logic [15:0] o_deck_rms_smoothed,
    input logic [15:0] o_deck_peak_held,
    input logic        o_public_facing,
    input logic [15:0] o_master_rms_smoothed,
    input logic [15:0] o_master_peak_held,
    input logic        o_warmup_complete,
    input logic        o_block_done
);

    localparam logic [4:0] DECKS_W = 5'(DECKS);

    logic r_warm_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_seen <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_warmup_complete) begin
            r_warm_seen <= 1'b1;
        end
    end

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_deck_rms_smoothed) && $stable(o_deck_peak_held) &&
            $stable(o_block_done) && $stable(o_master_peak_held))
        else $error("result beat changed while stalled");

    // Master fields are only filled on the last deck of a block.
    a_master_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_block_done |->
            (o_master_rms_smoothed == 16'd0) && (o_master_peak_held == 16'd0))
        else $error("master fields set on a beat that is not the last deck");

    // Once warm-up has been reported it stays reported.
    a_warm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_warm_seen |-> o_warmup_complete)
        else $error("warm-up flag dropped");

    // A deck number outside the meter reports no deck levels.
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({1'b0, o_deck_number} >= DECKS_W) |->
            (o_deck_rms_smoothed == 16'd0) && (o_deck_peak_held == 16'd0) &&
            !o_public_facing)
        else $error("deck levels reported for a deck beyond the meter");

    // Public facing needs a smoothed level above a threshold, so never zero.
    a_pub_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_public_facing |-> (o_deck_rms_smoothed != 16'd0))
        else $error("public facing with a silent deck");

endmodule

bind deck_level_meter dlm_checker #(
    .DECKS (DECKS)
) u_dlm_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_deck_number         (o_deck_number),
    .o_deck_rms_smoothed   (o_deck_rms_smoothed),
    .o_deck_peak_held      (o_deck_peak_held),
    .o_public_facing       (o_public_facing),
    .o_master_rms_smoothed (o_master_rms_smoothed),
    .o_master_peak_held    (o_master_peak_held),
    .o_warmup_complete     (o_warmup_complete),
    .o_block_done          (o_block_done)
);
